### rtl/dtl_pkg.sv
// Shared constants and types for the decision-tree leaf lookup block.
package dtl_pkg;

	// Fixed field widths of the request and response payloads
	localparam int SLOT_W    = 10;
	localparam int FSEL_W    = 8;
	localparam int FIELD_V_W = 32;

	// Number of indexes the fixed-width fields can address
	localparam int SLOT_SPAN = 1 << SLOT_W;
	localparam int FSEL_SPAN = 1 << FSEL_W;

	// Parameter defaults
	localparam int DEF_NODE_COUNT    = 1024;
	localparam int DEF_FEATURE_COUNT = 256;
	localparam int DEF_MAX_DEPTH     = 32;
	localparam int DEF_VALUE_WIDTH   = 32;

	// Request opcodes
	localparam logic [1:0] OP_WR_NODE = 2'd0;
	localparam logic [1:0] OP_WR_FEAT = 2'd1;
	localparam logic [1:0] OP_LOOKUP  = 2'd2;

	// Node entry fields kept beside the split value
	typedef struct packed {
		logic [FSEL_W-1:0] feature;
		logic              miss_left;
		logic [SLOT_W-1:0] left;
		logic [SLOT_W-1:0] right;
		logic              leaf;
	} node_fields_t;

	// Memory strobes from the walk controller to the tables
	typedef struct packed {
		logic node_we;
		logic node_re;
		logic feat_we;
		logic feat_re;
	} tbl_ctrl_t;

endpackage

### rtl/dtl_req_if.sv
// Request channel interface: valid/ready handshake with the request payload.
interface dtl_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  op;
	logic [dtl_pkg::SLOT_W-1:0]  slot;
	logic [dtl_pkg::FSEL_W-1:0]  test_feature;
	logic signed [dtl_pkg::FIELD_V_W-1:0] threshold;
	logic                        missing_goes_left;
	logic [dtl_pkg::SLOT_W-1:0]  left_node;
	logic [dtl_pkg::SLOT_W-1:0]  right_node;
	logic                        is_leaf;
	logic signed [dtl_pkg::FIELD_V_W-1:0] feature_value;
	logic                        feature_missing;

	modport source (
		output valid, op, slot, test_feature, threshold, missing_goes_left,
		       left_node, right_node, is_leaf, feature_value, feature_missing,
		input  ready
	);
	modport sink (
		input  valid, op, slot, test_feature, threshold, missing_goes_left,
		       left_node, right_node, is_leaf, feature_value, feature_missing,
		output ready
	);
endinterface

### rtl/dtl_rsp_if.sv
// Response channel interface: valid/ready handshake with the leaf result.
interface dtl_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [dtl_pkg::SLOT_W-1:0] leaf_index;
	logic                       depth_exceeded;

	modport source (output valid, leaf_index, depth_exceeded, input ready);
	modport sink (input valid, leaf_index, depth_exceeded, output ready);
endinterface

### rtl/dtl_tables.sv
// Node table and feature row memories, one write and one registered read port each.
module dtl_tables #(
	parameter int NODE_DEPTH = dtl_pkg::DEF_NODE_COUNT,
	parameter int NODE_AW    = $clog2(dtl_pkg::DEF_NODE_COUNT),
	parameter int NODE_W     = dtl_pkg::DEF_VALUE_WIDTH + $bits(dtl_pkg::node_fields_t),
	parameter int FEAT_DEPTH = dtl_pkg::DEF_FEATURE_COUNT,
	parameter int FEAT_AW    = $clog2(dtl_pkg::DEF_FEATURE_COUNT),
	parameter int FEAT_W     = dtl_pkg::DEF_VALUE_WIDTH + 1
) (
	input  logic                clk,
	input  dtl_pkg::tbl_ctrl_t  ctrl,
	input  logic [NODE_AW-1:0]  node_waddr,
	input  logic [NODE_W-1:0]   node_wdata,
	input  logic [NODE_AW-1:0]  node_raddr,
	output logic [NODE_W-1:0]   node_rdata,
	input  logic [FEAT_AW-1:0]  feat_waddr,
	input  logic [FEAT_W-1:0]   feat_wdata,
	input  logic [FEAT_AW-1:0]  feat_raddr,
	output logic [FEAT_W-1:0]   feat_rdata
);

	logic [NODE_W-1:0] node_mem [NODE_DEPTH];
	logic [FEAT_W-1:0] feat_mem [FEAT_DEPTH];

	// Node table: write port, registered read port
	always_ff @(posedge clk) begin
		if (ctrl.node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		if (ctrl.node_re) begin
			node_rdata <= node_mem[node_raddr];
		end
	end

	// Feature row: write port, registered read port
	always_ff @(posedge clk) begin
		if (ctrl.feat_we) begin
			feat_mem[feat_waddr] <= feat_wdata;
		end
		if (ctrl.feat_re) begin
			feat_rdata <= feat_mem[feat_raddr];
		end
	end

endmodule

### rtl/decision_tree_leaf_lookup.sv
// Top level of the decision-tree leaf lookup block.
//
// Requests arrive on req (valid/ready). Op 0 writes one node of the tree
// table, op 1 writes one feature value of the current row, op 2 walks the
// tree from node slot down to a leaf; op 3 is dropped. Writes and dropped
// ops return nothing. A lookup returns one response on rsp carrying the
// leaf index, the out-of-range slot at which the walk left the table, or
// the last node visited with depth_exceeded set once MAX_DEPTH moves
// passed without a leaf. Each move down the tree reads the node, then the
// feature value; a split feature beyond the row needs only the node read.
// req.ready returns with the response, so the block takes no new request
// until the last lookup has finished.
// req.ready is high only while no lookup is in flight.
// The response sits in an output register; the block takes new requests
// while it waits. When the receiver stalls and a second lookup finishes,
// that lookup holds its result until the register frees up.
// Reset clears the walk controller and the output valid; the memories are
// not cleared and must be written before they are read.
module decision_tree_leaf_lookup #(
	parameter int NODE_COUNT    = dtl_pkg::DEF_NODE_COUNT,
	parameter int FEATURE_COUNT = dtl_pkg::DEF_FEATURE_COUNT,
	parameter int MAX_DEPTH     = dtl_pkg::DEF_MAX_DEPTH,
	parameter int VALUE_WIDTH   = dtl_pkg::DEF_VALUE_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	dtl_req_if.sink    req,
	dtl_rsp_if.source  rsp
);

	localparam int NODE_DEPTH = (NODE_COUNT < dtl_pkg::SLOT_SPAN) ? NODE_COUNT
	                                                              : dtl_pkg::SLOT_SPAN;
	localparam int NODE_AW    = $clog2(NODE_DEPTH);
	localparam int FEAT_DEPTH = (FEATURE_COUNT < dtl_pkg::FSEL_SPAN) ? FEATURE_COUNT
	                                                                 : dtl_pkg::FSEL_SPAN;
	localparam int FEAT_AW    = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
	localparam int SW         = (VALUE_WIDTH < dtl_pkg::FIELD_V_W) ? VALUE_WIDTH
	                                                               : dtl_pkg::FIELD_V_W;
	localparam int NODE_W     = SW + $bits(dtl_pkg::node_fields_t);
	localparam int FEAT_W     = SW + 1;
	localparam int STEP_W     = $clog2(MAX_DEPTH + 1);
	localparam logic [31:0] NODE_LIM  = 32'(NODE_COUNT);
	localparam logic [31:0] FEAT_LIM  = 32'(FEATURE_COUNT);
	localparam logic [31:0] FEAT_DLIM = 32'(FEAT_DEPTH);
	localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_NODE = 4'b0010,
		S_FEAT = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [dtl_pkg::SLOT_W-1:0] node_q;
	logic [STEP_W-1:0]          steps_q;
	logic                       exc_q;
	logic [NODE_W-1:0]          cur_q;
	logic                       out_valid_q;
	logic [dtl_pkg::SLOT_W-1:0] out_leaf_q;
	logic                       out_exc_q;

	dtl_pkg::tbl_ctrl_t         ctrl;
	logic [NODE_AW-1:0]         node_raddr;
	logic [NODE_W-1:0]          node_rdata;
	logic [NODE_W-1:0]          node_wdata;
	logic [FEAT_W-1:0]          feat_rdata;
	logic [FEAT_W-1:0]          feat_wdata;
	dtl_pkg::node_fields_t      wr_f;
	dtl_pkg::node_fields_t      src_f;
	logic [SW-1:0]              src_split;
	logic                       acc;
	logic                       slot_node_ok;
	logic                       slot_feat_ok;
	logic                       feat_ok;
	logic                       f_missing;
	logic                       go_left;
	logic [dtl_pkg::SLOT_W-1:0] nxt;
	logic                       nxt_ok;
	logic                       at_limit;
	logic                       fin_go;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;

	// Range checks on the request slot; row entries past the memory are never written
	assign slot_node_ok = ({22'd0, req.slot} < NODE_LIM);
	assign slot_feat_ok = ({22'd0, req.slot} < FEAT_DLIM);

	// Pack write data, keeping the low value bits
	always_comb begin
		wr_f.feature   = req.test_feature;
		wr_f.miss_left = req.missing_goes_left;
		wr_f.left      = req.left_node;
		wr_f.right     = req.right_node;
		wr_f.leaf      = req.is_leaf;
	end
	assign node_wdata = {req.threshold[SW-1:0], wr_f};
	assign feat_wdata = {req.feature_missing, req.feature_value[SW-1:0]};

	// Select the current node: fresh from memory or held across the feature read
	always_comb begin
		if (state_q == S_FEAT) begin
			{src_split, src_f} = cur_q;
		end else begin
			{src_split, src_f} = node_rdata;
		end
	end

	// Branch decision for the current node
	assign feat_ok   = ({24'd0, src_f.feature} < FEAT_LIM);
	assign f_missing = (state_q == S_FEAT) ? feat_rdata[SW] : 1'b1;
	assign go_left   = f_missing ? src_f.miss_left
	                             : ($signed(feat_rdata[SW-1:0]) < $signed(src_split));
	assign nxt       = go_left ? src_f.left : src_f.right;
	assign nxt_ok    = ({22'd0, nxt} < NODE_LIM);
	assign at_limit  = (steps_q == STEP_MAX);
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	// Drive memory strobes and read addresses
	always_comb begin
		ctrl       = '0;
		node_raddr = nxt[NODE_AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (req.op)
						dtl_pkg::OP_WR_NODE: ctrl.node_we = slot_node_ok;
						dtl_pkg::OP_WR_FEAT: ctrl.feat_we = slot_feat_ok;
						dtl_pkg::OP_LOOKUP: begin
							ctrl.node_re = slot_node_ok;
							node_raddr   = req.slot[NODE_AW-1:0];
						end
						default: ;
					endcase
				end
			end
			S_NODE: begin
				if (!src_f.leaf && !at_limit) begin
					if (feat_ok) begin
						ctrl.feat_re = 1'b1;
					end else begin
						ctrl.node_re = nxt_ok;
					end
				end
			end
			S_FEAT: ctrl.node_re = nxt_ok;
			S_FIN: ;
			default: ;
		endcase
	end

	// Walk controller and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			node_q      <= '0;
			steps_q     <= '0;
			exc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc && req.op == dtl_pkg::OP_LOOKUP) begin
						node_q  <= req.slot;
						steps_q <= '0;
						exc_q   <= 1'b0;
						state_q <= slot_node_ok ? S_NODE : S_FIN;
					end
				end
				S_NODE: begin
					if (src_f.leaf) begin
						state_q <= S_FIN;
					end else if (at_limit) begin
						exc_q   <= 1'b1;
						state_q <= S_FIN;
					end else if (feat_ok) begin
						state_q <= S_FEAT;
					end else begin
						node_q  <= nxt;
						steps_q <= steps_q + 1'b1;
						state_q <= nxt_ok ? S_NODE : S_FIN;
					end
				end
				S_FEAT: begin
					node_q  <= nxt;
					steps_q <= steps_q + 1'b1;
					state_q <= nxt_ok ? S_NODE : S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the node entry across the feature read; load the result register
	always_ff @(posedge clk) begin
		if (state_q == S_NODE) begin
			cur_q <= node_rdata;
		end
		if (fin_go) begin
			out_leaf_q <= node_q;
			out_exc_q  <= exc_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.leaf_index     = out_leaf_q;
	assign rsp.depth_exceeded = out_exc_q;

	dtl_tables #(
		.NODE_DEPTH (NODE_DEPTH),
		.NODE_AW    (NODE_AW),
		.NODE_W     (NODE_W),
		.FEAT_DEPTH (FEAT_DEPTH),
		.FEAT_AW    (FEAT_AW),
		.FEAT_W     (FEAT_W)
	) u_tables (
		.clk        (clk),
		.ctrl       (ctrl),
		.node_waddr (req.slot[NODE_AW-1:0]),
		.node_wdata (node_wdata),
		.node_raddr (node_raddr),
		.node_rdata (node_rdata),
		.feat_waddr (req.slot[FEAT_AW-1:0]),
		.feat_wdata (feat_wdata),
		.feat_raddr (src_f.feature[FEAT_AW-1:0]),
		.feat_rdata (feat_rdata)
	);

endmodule

### rtl/dtl_checker.sv
// Port-level checks for the decision-tree leaf lookup block, bound to the top level.
module dtl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic [1:0]                 req_op,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [dtl_pkg::SLOT_W-1:0] rsp_leaf_index,
	input logic                       rsp_depth_exceeded
);

	// A lookup request blocks further requests in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op == dtl_pkg::OP_LOOKUP |=> !req_ready)
	else $error("request taken right after a lookup");

	// A write or dropped request leaves the block ready
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op != dtl_pkg::OP_LOOKUP |=> req_ready)
	else $error("block stalled after a write request");

	// A new response appears only when a lookup was in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
	else $error("response without a lookup in flight");

	// A stalled response holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_leaf_index)
		&& $stable(rsp_depth_exceeded))
	else $error("stalled response changed");

endmodule

bind decision_tree_leaf_lookup dtl_checker u_dtl_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.req_op             (req.op),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_leaf_index     (rsp.leaf_index),
	.rsp_depth_exceeded (rsp.depth_exceeded)
);

### tb/sv/dtl_leaf_checker.sv
// Leaf lookup checker: mirrors the tree and row tables and checks every response.
`timescale 1ns / 100ps

module dtl_leaf_checker #(
	parameter int NODE_COUNT    = dtl_pkg::DEF_NODE_COUNT,
	parameter int FEATURE_COUNT = dtl_pkg::DEF_FEATURE_COUNT,
	parameter int MAX_DEPTH     = dtl_pkg::DEF_MAX_DEPTH,
	parameter int VALUE_WIDTH   = dtl_pkg::DEF_VALUE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	dtl_req_if   req,
	dtl_rsp_if   rsp,
	output int   mismatch_count,
	output int   open_lookups
);

	typedef logic [dtl_pkg::SLOT_W-1:0] slot_t;

	typedef struct {
		dtl_pkg::node_fields_t link;
		logic signed [63:0]    threshold;
	} tree_node_t;

	typedef struct {
		logic signed [63:0] value;
		logic               absent;
	} row_value_t;

	typedef struct packed {
		slot_t leaf_index;
		logic  depth_exceeded;
	} leaf_result_t;

	tree_node_t   tree_nodes [NODE_COUNT];
	row_value_t   row_values [FEATURE_COUNT];
	leaf_result_t pending_leaves [$];

	// Keep the low VALUE_WIDTH bits of a Q16.16 field as a signed number
	function automatic logic signed [63:0] q_trim(
			input logic signed [dtl_pkg::FIELD_V_W-1:0] raw);
		logic signed [63:0] wide;
		wide = raw;
		return (wide <<< (64 - VALUE_WIDTH)) >>> (64 - VALUE_WIDTH);
	endfunction

	// Walk from the start node to a leaf, stopping after MAX_DEPTH moves
	function automatic leaf_result_t walk_tree(input slot_t start);
		int unsigned  at;
		int           moves;
		int unsigned  sel;
		logic         absent;
		logic         go_left;
		logic signed [63:0] val;
		leaf_result_t res;
		at = start;
		moves = 0;
		res.depth_exceeded = 1'b0;
		while (at < NODE_COUNT && !tree_nodes[at].link.leaf && !res.depth_exceeded) begin
			if (moves >= MAX_DEPTH) begin
				res.depth_exceeded = 1'b1;
			end else begin
				sel = tree_nodes[at].link.feature;
				// a split feature beyond the row counts as missing
				if (sel < FEATURE_COUNT) begin
					absent = row_values[sel].absent;
					val = row_values[sel].value;
				end else begin
					absent = 1'b1;
					val = '0;
				end
				go_left = absent ? tree_nodes[at].link.miss_left
				                 : (val < tree_nodes[at].threshold);
				at = go_left ? tree_nodes[at].link.left : tree_nodes[at].link.right;
				moves++;
			end
		end
		res.leaf_index = slot_t'(at);
		return res;
	endfunction

	// Check responses against the oldest prediction, then absorb the request
	always @(posedge clk or negedge arst_n) begin : track
		leaf_result_t want;
		dtl_pkg::node_fields_t link;
		if (!arst_n) begin
			pending_leaves.delete();
			mismatch_count = 0;
			open_lookups = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_leaves.size() == 0) begin
					$error("response with no lookup outstanding: %s %0d %s %0b",
						"leaf_index", rsp.leaf_index,
						"depth_exceeded", rsp.depth_exceeded);
					mismatch_count++;
				end else begin
					want = pending_leaves.pop_front();
					if (rsp.leaf_index !== want.leaf_index) begin
						$error("leaf_index: expected %0d, actual %0d",
							want.leaf_index, rsp.leaf_index);
						mismatch_count++;
					end
					if (rsp.depth_exceeded !== want.depth_exceeded) begin
						$error("depth_exceeded: expected %0b, actual %0b",
							want.depth_exceeded, rsp.depth_exceeded);
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				case (req.op)
					dtl_pkg::OP_WR_NODE: begin
						if (req.slot < NODE_COUNT) begin
							link.feature = req.test_feature;
							link.miss_left = req.missing_goes_left;
							link.left = req.left_node;
							link.right = req.right_node;
							link.leaf = req.is_leaf;
							tree_nodes[req.slot].link = link;
							tree_nodes[req.slot].threshold = q_trim(req.threshold);
						end
					end
					dtl_pkg::OP_WR_FEAT: begin
						if (req.slot < FEATURE_COUNT) begin
							row_values[req.slot].value = q_trim(req.feature_value);
							row_values[req.slot].absent = req.feature_missing;
						end
					end
					dtl_pkg::OP_LOOKUP: begin
						pending_leaves.push_back(walk_tree(req.slot));
					end
					default: begin
						// unused op: drop it
					end
				endcase
			end
			open_lookups = pending_leaves.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
// Testbench top: builds trees and rows, issues lookups and reports the verdict.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_TARGET     = 1600;
	localparam int HOLD_CYCLES     = 500;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = 80;
	localparam int MAX_DEPTH_PROBE = dtl_pkg::DEF_MAX_DEPTH;
	localparam int SLOT_SPAN       = dtl_pkg::SLOT_SPAN;
	localparam int FSEL_SPAN       = dtl_pkg::FSEL_SPAN;
	localparam int ROW_COUNT       = dtl_pkg::DEF_FEATURE_COUNT;

	typedef logic [dtl_pkg::SLOT_W-1:0] slot_t;
	typedef logic [dtl_pkg::FSEL_W-1:0] fsel_t;
	typedef logic signed [dtl_pkg::FIELD_V_W-1:0] q16_t;

	typedef struct packed {
		logic [1:0] op;
		slot_t      slot;
		fsel_t      test_feature;
		q16_t       threshold;
		logic       missing_goes_left;
		slot_t      left_node;
		slot_t      right_node;
		logic       is_leaf;
		q16_t       feature_value;
		logic       feature_missing;
	} req_item_t;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   open_lookups;

	dtl_req_if req_ch ();
	dtl_rsp_if rsp_ch ();

	decision_tree_leaf_lookup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	dtl_leaf_checker leaf_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.open_lookups   (open_lookups)
	);

	// Stimulus bookkeeping: which entries hold data, so no walk reads an empty one
	bit   node_known [SLOT_SPAN];
	int   built_nodes [$];
	bit   feat_known [FSEL_SPAN];
	int   known_feats [$];
	q16_t feat_shadow [FSEL_SPAN];
	int   path_stamp [SLOT_SPAN];
	int   chain_count;
	int   sent_items;
	int   burst_left;
	bit   hold_off_arm;
	int   quiet_cycles;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic req_item_t random_item(input logic [1:0] op);
		req_item_t it;
		it.op = op;
		it.slot = slot_t'($urandom_range(0, SLOT_SPAN - 1));
		it.test_feature = fsel_t'($urandom);
		it.threshold = $urandom;
		it.missing_goes_left = 1'($urandom);
		it.left_node = slot_t'($urandom);
		it.right_node = slot_t'($urandom);
		it.is_leaf = 1'($urandom);
		it.feature_value = $urandom;
		it.feature_missing = 1'($urandom);
		return it;
	endfunction

	function automatic int any_node();
		return built_nodes[$urandom_range(0, built_nodes.size() - 1)];
	endfunction

	function automatic int any_feature();
		return known_feats[$urandom_range(0, known_feats.size() - 1)];
	endfunction

	// Pick a threshold or value: extremes, small numbers, near a row value, or any value
	function automatic q16_t q16_pick();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			3, 4: return feat_shadow[any_feature()] + $signed($urandom_range(0, 2)) - 1;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_child(input int slot);
		return ($urandom_range(0, 7) == 0) ? slot : any_node();
	endfunction

	function automatic req_item_t leaf_node(input int slot);
		req_item_t it;
		it = random_item(dtl_pkg::OP_WR_NODE);
		it.slot = slot_t'(slot);
		it.is_leaf = 1'b1;
		return it;
	endfunction

	function automatic req_item_t inner_node(input int slot, input int lc, input int rc);
		req_item_t it;
		it = random_item(dtl_pkg::OP_WR_NODE);
		it.slot = slot_t'(slot);
		it.test_feature = fsel_t'(any_feature());
		it.threshold = q16_pick();
		it.left_node = slot_t'(lc);
		it.right_node = slot_t'(rc);
		it.is_leaf = 1'b0;
		return it;
	endfunction

	// Offer one request in bursts with random gaps; return once it is taken
	task automatic put_request(input req_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.op <= it.op;
		req_ch.slot <= it.slot;
		req_ch.test_feature <= it.test_feature;
		req_ch.threshold <= it.threshold;
		req_ch.missing_goes_left <= it.missing_goes_left;
		req_ch.left_node <= it.left_node;
		req_ch.right_node <= it.right_node;
		req_ch.is_leaf <= it.is_leaf;
		req_ch.feature_value <= it.feature_value;
		req_ch.feature_missing <= it.feature_missing;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		if (it.op != OP_UNUSED) sent_items++;
	endtask

	task automatic write_node(input req_item_t it);
		if (!node_known[it.slot]) begin
			node_known[it.slot] = 1'b1;
			built_nodes.push_back(int'(it.slot));
		end
		put_request(it);
	endtask

	task automatic write_feature(input int idx, input q16_t value, input bit missing);
		req_item_t it;
		it = random_item(dtl_pkg::OP_WR_FEAT);
		it.slot = slot_t'(idx);
		it.feature_value = value;
		it.feature_missing = missing;
		// indexes past the row are dropped by the block
		if (idx < ROW_COUNT) begin
			if (!feat_known[idx]) begin
				feat_known[idx] = 1'b1;
				known_feats.push_back(idx);
			end
			feat_shadow[idx] = value;
		end
		put_request(it);
	endtask

	task automatic lookup(input int slot);
		req_item_t it;
		it = random_item(dtl_pkg::OP_LOOKUP);
		it.slot = slot_t'(slot);
		put_request(it);
	endtask

	// Hold the sender until every lookup has answered
	task automatic drain_lookups();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (open_lookups != 0);
		@(posedge clk);
	endtask

	// Build a path of distinct inner nodes above a fresh leaf, then walk it
	task automatic grow_chain();
		int depth;
		int s;
		int prev;
		bit strict;
		int members [$];
		case (chain_count)
			0: depth = MAX_DEPTH_PROBE;
			1: depth = MAX_DEPTH_PROBE + 1;
			2: depth = MAX_DEPTH_PROBE - 1;
			default: depth = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
			                                              : $urandom_range(1, 12);
		endcase
		strict = (chain_count < 3) || ($urandom_range(0, 1) == 0);
		chain_count++;
		s = $urandom_range(0, SLOT_SPAN - 1);
		path_stamp[s] = chain_count;
		write_node(leaf_node(s));
		prev = s;
		repeat (depth) begin
			do s = $urandom_range(0, SLOT_SPAN - 1); while (path_stamp[s] == chain_count);
			path_stamp[s] = chain_count;
			members.push_back(s);
			if (strict) write_node(inner_node(s, prev, prev));
			else if ($urandom_range(0, 1)) write_node(inner_node(s, prev, pick_child(s)));
			else write_node(inner_node(s, pick_child(s), prev));
			prev = s;
		end
		lookup(prev);
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(0, 3) == 0)
				write_feature(any_feature(), q16_pick(), $urandom_range(0, 3) == 0);
			lookup(members[$urandom_range(0, members.size() - 1)]);
		end
	endtask

	// Rewrite random nodes as leaves or inner nodes and look up as we go
	task automatic reshape_nodes();
		int s;
		repeat ($urandom_range(2, 8)) begin
			s = $urandom_range(0, SLOT_SPAN - 1);
			if ($urandom_range(0, 2) == 0) write_node(leaf_node(s));
			else write_node(inner_node(s, pick_child(s), pick_child(s)));
			if ($urandom_range(0, 1)) lookup(any_node());
		end
	endtask

	// Receiver: ready pattern in stretches of set density, plus one long hold
	initial begin : sink_pace
		int  level;
		int  span;
		bit  held_once;
		held_once = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			case ($urandom_range(0, 3))
				0: level = 100;
				1: level = 75;
				2: level = 40;
				default: level = 10;
			endcase
			span = $urandom_range(50, 300);
			while (span > 0 && !(hold_off_arm && !held_once)) begin
				rsp_ch.ready <= ($urandom_range(1, 100) <= level);
				@(posedge clk);
				span--;
			end
			if (hold_off_arm && !held_once) begin
				held_once = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("decision_tree_leaf_lookup test failed");
			$finish;
		end
	end

	initial begin : stimulus
		req_item_t it;
		arst_n = 1'b0;
		hold_off_arm = 1'b0;
		chain_count = 0;
		sent_items = 0;
		burst_left = 0;
		req_ch.valid <= 1'b0;
		req_ch.op <= dtl_pkg::OP_WR_NODE;
		req_ch.slot <= '0;
		req_ch.test_feature <= '0;
		req_ch.threshold <= '0;
		req_ch.missing_goes_left <= 1'b0;
		req_ch.left_node <= '0;
		req_ch.right_node <= '0;
		req_ch.is_leaf <= 1'b0;
		req_ch.feature_value <= '0;
		req_ch.feature_missing <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the row: both value extremes, a missing value, zero
		write_feature(0, 32'sh7FFF_FFFF, 1'b0);
		write_feature(ROW_COUNT - 1, 32'sh8000_0000, 1'b0);
		write_feature(1, $urandom, 1'b1);
		write_feature(2, '0, 1'b0);
		write_node(leaf_node(SLOT_SPAN - 1));
		write_node(leaf_node(0));

		// Value equal to the split goes right
		it = inner_node(5, 0, SLOT_SPAN - 1);
		it.test_feature = fsel_t'(0);
		it.threshold = 32'sh7FFF_FFFF;
		write_node(it);
		lookup(5);
		it = inner_node(6, SLOT_SPAN - 1, 0);
		it.test_feature = fsel_t'(ROW_COUNT - 1);
		it.threshold = 32'sh8000_0000;
		write_node(it);
		lookup(6);

		// Value just below the split goes left
		it = inner_node(7, SLOT_SPAN - 1, 0);
		it.test_feature = fsel_t'(ROW_COUNT - 1);
		it.threshold = 32'sh8000_0001;
		write_node(it);
		lookup(7);

		// A feature write past the row must not land on a row entry
		write_feature(SLOT_SPAN - 1, 32'sh7FFF_FFFF, 1'b0);
		lookup(7);

		// Missing value follows the node's missing direction
		it = inner_node(8, 0, SLOT_SPAN - 1);
		it.test_feature = fsel_t'(1);
		it.missing_goes_left = 1'b1;
		write_node(it);
		it = inner_node(9, 0, SLOT_SPAN - 1);
		it.test_feature = fsel_t'(1);
		it.missing_goes_left = 1'b0;
		write_node(it);
		lookup(8);
		lookup(9);

		// Self loop runs into the depth limit
		it = inner_node(10, 10, 10);
		it.test_feature = fsel_t'(2);
		write_node(it);
		lookup(10);

		// Two moves, then a lookup that starts on a leaf
		it = inner_node(11, SLOT_SPAN - 1, 5);
		it.test_feature = fsel_t'(0);
		it.threshold = 32'sh8000_0000;
		write_node(it);
		lookup(11);
		lookup(SLOT_SPAN - 1);

		// Unused op is dropped
		put_request(random_item(OP_UNUSED));
		drain_lookups();

		// Random part: start with lookups while the receiver holds off
		hold_off_arm = 1'b1;
		repeat (6) lookup(any_node());
		while (sent_items < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: grow_chain();
				4, 5: reshape_nodes();
				6: begin
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 1)) put_request(random_item(OP_UNUSED));
						else write_feature($urandom_range(ROW_COUNT, SLOT_SPAN - 1),
							$urandom, 1'($urandom));
					end
				end
				7, 8: repeat ($urandom_range(2, 10)) lookup(any_node());
				default: begin
					if ($urandom_range(0, 3) == 0) drain_lookups();
					else repeat ($urandom_range(1, 4))
						write_feature($urandom_range(0, ROW_COUNT - 1), q16_pick(),
							$urandom_range(0, 3) == 0);
				end
			endcase
		end

		// Let the last responses come back, then settle
		drain_lookups();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && open_lookups == 0)
			$display("decision_tree_leaf_lookup test passed");
		else
			$display("decision_tree_leaf_lookup test failed");
		$finish;
	end

endmodule

### sim.f
rtl/dtl_pkg.sv
rtl/dtl_req_if.sv
rtl/dtl_rsp_if.sv
rtl/dtl_tables.sv
rtl/decision_tree_leaf_lookup.sv
rtl/dtl_checker.sv
tb/sv/dtl_leaf_checker.sv
tb/sv/tb_top.sv
